// ===== design/mips_load_store_unit_with_mmio_assert.svh =====
// Assertion macros used by the load/store unit top level.
`ifndef MIPS_LOAD_STORE_UNIT_WITH_MMIO_ASSERT_SVH
`define MIPS_LOAD_STORE_UNIT_WITH_MMIO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mlsu_pkg.sv =====
// Types, constants and codes shared by the load/store unit modules.
`timescale 1ns / 1ps
`default_nettype none

package mlsu_pkg;

  localparam int AddrBits    = 16;
  localparam int RamRowBits  = AddrBits - 2;
  localparam int RamRows     = 1 << RamRowBits;
  localparam int WordBytes   = 4;
  localparam int MmioWords   = 4;
  localparam int PaddrW      = 3;

  localparam logic [31:0] MmioBase = 32'hffff0000;
  localparam logic [27:0] MmioTag  = MmioBase[31:4];

  localparam logic [1:0] MmioInReady  = 2'd0;
  localparam logic [1:0] MmioInData   = 2'd1;
  localparam logic [1:0] MmioOutReady = 2'd2;
  localparam logic [1:0] MmioOutData  = 2'd3;

  localparam logic [PaddrW-3:0] RegLittleEndian = 1'b0;

  typedef enum logic [2:0] {
    ActLoadByte  = 3'd0,
    ActLoadHalf  = 3'd1,
    ActLoadWord  = 3'd2,
    ActStoreByte = 3'd3,
    ActStoreHalf = 3'd4,
    ActStoreWord = 3'd5,
    ActRawRead   = 3'd6,
    ActRawWrite  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    FaultNone       = 2'd0,
    FaultLoadAlign  = 2'd1,
    FaultStoreAlign = 2'd2,
    FaultReadOnly   = 2'd3
  } fault_e;

  typedef logic [WordBytes-1:0][7:0] row_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    fault_e      fault;
  } out_item_t;

  typedef struct packed {
    fault_e                fault;
    logic                  is_mmio;
    logic [1:0]            offset;
    logic [RamRowBits-1:0] ram_row;
    logic [1:0]            mmio_row;
    logic [WordBytes-1:0]  byte_en;
    row_t                  wdata;
    logic                  clr_in_ready;
    logic                  clr_out_ready;
  } access_t;

endpackage

`default_nettype wire

// ===== design/mlsu_decode.sv =====
// Decodes one access into faults, byte lanes, row addresses and side effects.
`timescale 1ns / 1ps
`default_nettype none

module mlsu_decode import mlsu_pkg::*; (
  input  in_item_t item_i,
  input  logic     little_endian_i,
  output access_t  acc_o
);

  logic       mis;
  logic [1:0] off;
  logic [1:0] off_hi;
  logic [1:0] wsel;
  logic       is_mmio;
  logic [31:0] d;

  always_comb begin
    off     = item_i.address[1:0];
    off_hi  = {off[1], 1'b1};
    wsel    = item_i.address[3:2];
    is_mmio = (item_i.address[31:4] == MmioTag);
    d       = item_i.write_data;

    case (item_i.action)
      ActLoadHalf, ActStoreHalf: mis = off[0];
      ActLoadWord, ActStoreWord: mis = |off;
      default:                   mis = 1'b0;
    endcase

    acc_o               = '0;
    acc_o.fault         = FaultNone;
    acc_o.is_mmio       = is_mmio;
    acc_o.offset        = off;
    acc_o.ram_row       = item_i.address[AddrBits-1:2];
    acc_o.mmio_row      = wsel;

    case (item_i.action)
      ActLoadByte, ActLoadHalf, ActLoadWord: begin
        if (mis) begin
          acc_o.fault = FaultLoadAlign;
        end else begin
          acc_o.clr_in_ready = is_mmio && (wsel == MmioInData);
        end
      end
      ActStoreByte, ActStoreHalf, ActStoreWord: begin
        if (mis) begin
          acc_o.fault = FaultStoreAlign;
        end else if (is_mmio && (wsel != MmioOutData)) begin
          acc_o.fault = FaultReadOnly;
        end else begin
          acc_o.clr_out_ready = is_mmio && (wsel == MmioOutData);
          case (item_i.action)
            ActStoreByte: begin
              acc_o.byte_en[off] = 1'b1;
              acc_o.wdata[off]   = d[7:0];
            end
            ActStoreHalf: begin
              acc_o.byte_en[off]    = 1'b1;
              acc_o.byte_en[off_hi] = 1'b1;
              if (little_endian_i) begin
                acc_o.wdata[off]    = d[7:0];
                acc_o.wdata[off_hi] = d[15:8];
              end else begin
                acc_o.wdata[off]    = d[15:8];
                acc_o.wdata[off_hi] = d[7:0];
              end
            end
            default: begin
              acc_o.byte_en = '1;
              if (little_endian_i) begin
                acc_o.wdata = d;
              end else begin
                acc_o.wdata = {d[7:0], d[15:8], d[23:16], d[31:24]};
              end
            end
          endcase
        end
      end
      ActRawWrite: begin
        acc_o.byte_en[off] = 1'b1;
        acc_o.wdata[off]   = d[7:0];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/mlsu_ram.sv =====
// Word-row byte-lane RAM window with a zero-fill sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module mlsu_ram import mlsu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_i,
  input  logic [RamRowBits-1:0] row_i,
  input  logic [WordBytes-1:0]  byte_en_i,
  input  row_t                  wdata_i,
  output row_t                  rdata_o,
  output logic                  clearing_o
);

  row_t                  mem [RamRows];
  row_t                  rdata_q;
  logic                  clearing_q, clearing_d;
  logic [RamRowBits-1:0] clr_idx_q, clr_idx_d;
  logic [RamRowBits-1:0] wr_row;
  logic [WordBytes-1:0]  wr_en;
  row_t                  wr_data;

  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (&clr_idx_q) begin
        clearing_d = 1'b0;
      end
    end
    if (clearing_q) begin
      wr_row  = clr_idx_q;
      wr_en   = '1;
      wr_data = '0;
    end else begin
      wr_row  = row_i;
      wr_en   = req_i ? byte_en_i : '0;
      wr_data = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < WordBytes; j++) begin
      if (wr_en[j]) begin
        mem[wr_row][j] <= wr_data[j];
      end
    end
    if (req_i) begin
      rdata_q <= mem[row_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

`default_nettype wire

// ===== design/mlsu_mmio.sv =====
// Memory-mapped keyboard and display words with their ready-clearing side effects.
`timescale 1ns / 1ps
`default_nettype none

module mlsu_mmio import mlsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_i,
  input  access_t acc_i,
  output row_t    rdata_o
);

  row_t regs_q [MmioWords];
  row_t rdata_q;
  logic wr;

  assign wr = req_i && acc_i.is_mmio;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MmioWords; w++) begin
        regs_q[w] <= '0;
      end
    end else if (wr) begin
      if (acc_i.clr_in_ready) begin
        regs_q[MmioInReady] <= '0;
      end
      if (acc_i.clr_out_ready) begin
        regs_q[MmioOutReady] <= '0;
      end
      for (int j = 0; j < WordBytes; j++) begin
        if (acc_i.byte_en[j]) begin
          regs_q[acc_i.mmio_row][j] <= acc_i.wdata[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      rdata_q <= regs_q[acc_i.mmio_row];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/mips_load_store_unit_with_mmio.sv =====
// Top level of the MIPS load/store unit with keyboard and display MMIO.
`timescale 1ns / 1ps
`default_nettype none
`include "mips_load_store_unit_with_mmio_assert.svh"

// One item is accepted per cycle unless a stalled output holds the first stage.
// The accepting edge reads and writes the RAM row and MMIO word and loads the
// first stage; the result register loads when that stage advances. After reset
// the RAM window is zero-filled one four-byte row per cycle over 2^(AddrBits-2)
// = 16384 rows; input stays stalled during that pass while configuration writes
// are still taken. The little_endian register lies at APB address 0, resets to 1.
module mips_load_store_unit_with_mmio import mlsu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic      le_q;
  logic      cfg_sel;
  access_t   acc;
  logic      accept;
  logic      clearing;
  row_t      ram_rdata;
  row_t      mmio_rdata;

  logic      s1_valid_q;
  action_e   s1_action_q;
  fault_e    s1_fault_q;
  logic      s1_mmio_q;
  logic [1:0] s1_off_q;
  logic      s1_adv;

  logic      out_valid_q;
  out_item_t out_q, out_d;
  row_t      row;
  logic [1:0] off_hi;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PaddrW-1:2] == RegLittleEndian);
  assign prdata  = cfg_sel ? {31'b0, le_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      le_q <= pwdata[0];
    end
  end

  mlsu_decode u_decode (
    .item_i          (in_item_i),
    .little_endian_i (le_q),
    .acc_o           (acc)
  );

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  mlsu_ram u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (accept && !acc.is_mmio),
    .row_i      (acc.ram_row),
    .byte_en_i  (acc.byte_en),
    .wdata_i    (acc.wdata),
    .rdata_o    (ram_rdata),
    .clearing_o (clearing)
  );

  mlsu_mmio u_mmio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (accept),
    .acc_i   (acc),
    .rdata_o (mmio_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !s1_adv);
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= in_item_i.action;
      s1_fault_q  <= acc.fault;
      s1_mmio_q   <= acc.is_mmio;
      s1_off_q    <= acc.offset;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    row            = s1_mmio_q ? mmio_rdata : ram_rdata;
    off_hi         = {s1_off_q[1], 1'b1};
    out_d.fault    = s1_fault_q;
    out_d.read_data = '0;
    if (s1_fault_q == FaultNone) begin
      case (s1_action_q)
        ActLoadByte, ActRawRead: begin
          out_d.read_data = {24'b0, row[s1_off_q]};
        end
        ActLoadHalf: begin
          if (le_q) begin
            out_d.read_data = {16'b0, row[off_hi], row[s1_off_q]};
          end else begin
            out_d.read_data = {16'b0, row[s1_off_q], row[off_hi]};
          end
        end
        ActLoadWord: begin
          if (le_q) begin
            out_d.read_data = row;
          end else begin
            out_d.read_data = {row[0], row[1], row[2], row[3]};
          end
        end
        default: begin
          out_d.read_data = '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MLSU_ASSERT_NOW(a_clear_blocks_input, clk_i, rst_ni, clearing, in_stall_o,
                   "item accepted during RAM clearing pass")
  `MLSU_ASSERT_NOW(a_fault_zero_data, clk_i, rst_ni,
                   out_valid_o && (out_item_o.fault != FaultNone),
                   out_item_o.read_data == 32'b0, "faulting item returned data")
  `MLSU_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, accept, s1_valid_q,
                    "accepted item lost before result stage")
  `MLSU_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q,
                    "stalled item dropped from first stage")

endmodule

`default_nettype wire
